### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDRF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ldrf_pkg.sv
package ldrf_pkg;

  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int PARAM_WIDTH     = 31;
  localparam int ENERGY_WIDTH    = 31;
  localparam int FORCE_WIDTH     = 32;
  localparam int QUO_WIDTH       = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STRENGTH = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET   = 4'd1;

  localparam logic [PARAM_WIDTH-1:0] STRENGTH_RESET = 31'd65536;
  localparam logic [PARAM_WIDTH-1:0] TARGET_RESET   = 31'd65536;

  localparam logic [FORCE_WIDTH-1:0]  FORCE_MAX  = 32'h7FFF_FFFF;
  localparam logic [FORCE_WIDTH-1:0]  FORCE_MIN  = 32'h8000_0000;
  localparam logic [ENERGY_WIDTH-1:0] ENERGY_MAX = 31'h7FFF_FFFF;

endpackage

### rtl/core/ldrf_ifs.sv
interface ldrf_point_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_a_x;
  logic signed [COORD_WIDTH-1:0] pos_a_y;
  logic signed [COORD_WIDTH-1:0] pos_a_z;
  logic signed [COORD_WIDTH-1:0] pos_b_x;
  logic signed [COORD_WIDTH-1:0] pos_b_y;
  logic signed [COORD_WIDTH-1:0] pos_b_z;
  modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  input ready);
  modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                output ready);
endinterface

interface ldrf_result_if;
  logic                                   valid;
  logic                                   ready;
  logic        [ldrf_pkg::ENERGY_WIDTH-1:0] energy;
  logic signed [ldrf_pkg::FORCE_WIDTH-1:0]  force_x;
  logic signed [ldrf_pkg::FORCE_WIDTH-1:0]  force_y;
  logic signed [ldrf_pkg::FORCE_WIDTH-1:0]  force_z;
  logic                                   saturated;
  modport source (output valid, energy, force_x, force_y, force_z, saturated,
                  input ready);
  modport sink (input valid, energy, force_x, force_y, force_z, saturated,
                output ready);
endinterface

interface ldrf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ldrf_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [ldrf_pkg::CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ldrf_div_pipe.sv
module ldrf_div_pipe #(
  parameter int NUM_WIDTH = 64,
  parameter int DEN_WIDTH = 32,
  parameter int QUO_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  output logic [QUO_WIDTH-1:0] quo,
  output logic                 over
);

  localparam int HW = NUM_WIDTH - QUO_WIDTH;
  localparam int CW = (HW > DEN_WIDTH) ? HW : DEN_WIDTH;

  logic [DEN_WIDTH-1:0] rem [QUO_WIDTH+1];
  logic [DEN_WIDTH-1:0] dn  [QUO_WIDTH+1];
  logic [QUO_WIDTH-1:0] low [QUO_WIDTH+1];
  logic [QUO_WIDTH-1:0] q   [QUO_WIDTH+1];
  logic                 ov  [QUO_WIDTH+1];

  // A quotient wider than QUO_WIDTH bits shows as over; otherwise the upper
  // part of the numerator is already below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DEN_WIDTH'(num[NUM_WIDTH-1:QUO_WIDTH]);
      ov[0]  <= CW'(num[NUM_WIDTH-1:QUO_WIDTH]) >= CW'(den);
      low[0] <= num[QUO_WIDTH-1:0];
      dn[0]  <= den;
      q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QUO_WIDTH; j++) begin : g_step
    logic [DEN_WIDTH:0] rsh;
    logic [DEN_WIDTH:0] rsub;
    logic               ge;
    always_comb begin
      rsh  = {rem[j], low[j][QUO_WIDTH-1]};
      rsub = rsh - {1'b0, dn[j]};
      ge   = rsh >= {1'b0, dn[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? rsub[DEN_WIDTH-1:0] : rsh[DEN_WIDTH-1:0];
        q[j+1]   <= {q[j][QUO_WIDTH-2:0], ge};
        low[j+1] <= {low[j][QUO_WIDTH-2:0], 1'b0};
        dn[j+1]  <= dn[j];
        ov[j+1]  <= ov[j];
      end
    end
  end

  assign quo  = q[QUO_WIDTH];
  assign over = ov[QUO_WIDTH];

endmodule

### rtl/core/linear_distance_restraint_force.sv
// Channel  Modport  Request
// cfg      sink     register index and write data
// point    sink     points a and b, three coordinates each
// result   source   energy, force on a and saturation flag
//
// One request is taken every cycle while point.ready is high; each request runs
// through the bit-serial square root (one root bit per stage) and the quotient
// dividers to the output register.
// Reset clears the valid bits and loads both registers with 1.0.
// A stalled output holds; one further result lands in a skid register, after
// which the whole pipeline holds and point.ready falls.
`include "assert_macros.svh"

module linear_distance_restraint_force #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  ldrf_cfg_if.sink     cfg,
  ldrf_point_if.sink   point,
  ldrf_result_if.source result
);

  localparam int AW   = ldrf_pkg::PARAM_WIDTH;
  localparam int QW   = ldrf_pkg::QUO_WIDTH;
  localparam int FW   = ldrf_pkg::FORCE_WIDTH;
  localparam int EW   = ldrf_pkg::ENERGY_WIDTH;
  localparam int MW   = COORD_WIDTH + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int MHW  = MW - H;
  localparam int RW   = MW + 1;
  localparam int SW   = 2 * RW;
  localparam int RMW  = RW + 3;
  localparam int RH   = (RW + 1) / 2;
  localparam int RHW  = RW - RH;
  localparam int NFW  = AW + MW + FRAC_BITS;
  localparam int DW   = AW + RW;
  localparam int NEW  = AW + RW;
  localparam int PA   = 4 + RW;
  localparam int P1   = PA + 1;
  localparam int P2   = PA + 2;
  localparam int LAST = P2 + QW + 1;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
  } ax_t;

  typedef struct packed {
    logic [2:0] zero;
    logic [2:0] neg;
  } fl_t;

  typedef struct packed {
    logic [EW-1:0]      energy;
    logic [2:0][FW-1:0] frc;
    logic               sat;
  } res_t;

  logic [AW-1:0] strength;
  logic [AW-1:0] target;
  logic [AW-1:0] tgt;

  logic          en;
  logic          v   [1:LAST];
  ax_t           ax  [1:PA];
  fl_t           fl  [P1:LAST];

  logic [COORD_WIDTH-1:0] pa [3];
  logic [COORD_WIDTH-1:0] pb [3];
  ax_t                    ax_in;

  logic [2*H-1:0]     pp_ll [3];
  logic [MHW+H-1:0]   pp_lh [3];
  logic [2*MHW-1:0]   pp_hh [3];
  logic [SW-1:0]      sq3   [3];

  logic [RMW-1:0] sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  logic [SW-1:0]  sq_s    [RW+1];

  logic [RW-1:0]      root;
  logic [AW+RH-1:0]   pe_lo;
  logic [AW+RHW-1:0]  pe_hi;
  logic [AW+RH-1:0]   pd_lo;
  logic [AW+RHW-1:0]  pd_hi;
  logic [AW+H-1:0]    pf_lo [3];
  logic [AW+MHW-1:0]  pf_hi [3];
  logic [NEW-1:0]     e_num;
  logic [DW-1:0]      f_den;
  logic [NFW-1:0]     f_num [3];

  logic [QW-1:0] e_q;
  logic          e_ov;
  logic [QW-1:0] f_q  [3];
  logic          f_ov [3];

  res_t res;
  res_t out_r;
  res_t skid_r;
  logic out_v;
  logic skid_v;

  // Configuration.
  assign cfg.ready = 1'b1;
  assign tgt = (target == '0) ? AW'(1) : target;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= ldrf_pkg::STRENGTH_RESET;
      target   <= ldrf_pkg::TARGET_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == ldrf_pkg::REG_STRENGTH) begin
        strength <= cfg.data[AW-1:0];
      end else if (cfg.index == ldrf_pkg::REG_TARGET) begin
        target <= cfg.data[AW-1:0];
      end
    end
  end

  assign en          = !skid_v;
  assign point.ready = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[1] <= point.valid;
      for (int k = 2; k <= LAST; k++) v[k] <= v[k-1];
    end
  end

  // Difference and magnitude.
  assign pa[0] = point.pos_a_x;
  assign pa[1] = point.pos_a_y;
  assign pa[2] = point.pos_a_z;
  assign pb[0] = point.pos_b_x;
  assign pb[1] = point.pos_b_y;
  assign pb[2] = point.pos_b_z;

  always_comb begin
    logic [MW-1:0] dif;
    for (int i = 0; i < 3; i++) begin
      dif = {pa[i][COORD_WIDTH-1], pa[i]} - {pb[i][COORD_WIDTH-1], pb[i]};
      ax_in.neg[i] = dif[MW-1];
      ax_in.mag[i] = dif[MW-1] ? (~dif + 1'b1) : dif;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax[1] <= ax_in;
      for (int k = 2; k <= PA; k++) ax[k] <= ax[k-1];
    end
  end

  // Squares from half-width partial products, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp_ll[i] <= ax[1].mag[i][H-1:0] * ax[1].mag[i][H-1:0];
        pp_lh[i] <= ax[1].mag[i][MW-1:H] * ax[1].mag[i][H-1:0];
        pp_hh[i] <= ax[1].mag[i][MW-1:H] * ax[1].mag[i][MW-1:H];
        sq3[i]   <= SW'(pp_ll[i]) + (SW'(pp_lh[i]) << (H + 1)) + (SW'(pp_hh[i]) << (2 * H));
      end
      sq_s[0]    <= sq3[0] + sq3[1] + sq3[2];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // Square root, one root bit per stage.
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;
    always_comb begin
      rem_sh = {sq_rem[j][RMW-3:0], sq_s[j][SW-1 -: 2]};
      trial  = {1'b0, sq_root[j], 2'b01};
      ge     = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j+1]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root[j+1] <= {sq_root[j][RW-2:0], ge};
        sq_s[j+1]    <= {sq_s[j][SW-3:0], 2'b00};
      end
    end
  end

  assign root = sq_root[RW];

  // Products for energy, divisor and force numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      pe_lo <= strength * root[RH-1:0];
      pe_hi <= strength * root[RW-1:RH];
      pd_lo <= tgt * root[RH-1:0];
      pd_hi <= tgt * root[RW-1:RH];
      for (int i = 0; i < 3; i++) begin
        pf_lo[i]      <= strength * ax[PA].mag[i][H-1:0];
        pf_hi[i]      <= strength * ax[PA].mag[i][MW-1:H];
        fl[P1].zero[i] <= (root == '0) || (DW'(root) == DW'(tgt)) || (ax[PA].mag[i] == '0);
        fl[P1].neg[i]  <= ax[PA].neg[i] ^ (DW'(root) > DW'(tgt));
      end
      e_num <= NEW'(pe_lo) + (NEW'(pe_hi) << RH);
      f_den <= DW'(pd_lo) + (DW'(pd_hi) << RH);
      for (int i = 0; i < 3; i++) begin
        f_num[i] <= (NFW'(pf_lo[i]) + (NFW'(pf_hi[i]) << H)) << FRAC_BITS;
      end
      for (int k = P2; k <= LAST; k++) fl[k] <= fl[k-1];
    end
  end

  ldrf_div_pipe #(.NUM_WIDTH(NEW), .DEN_WIDTH(AW), .QUO_WIDTH(QW)) u_div_e (
    .clk  (clk),
    .en   (en),
    .num  (e_num),
    .den  (tgt),
    .quo  (e_q),
    .over (e_ov)
  );

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    ldrf_div_pipe #(.NUM_WIDTH(NFW), .DEN_WIDTH(DW), .QUO_WIDTH(QW)) u_div_f (
      .clk  (clk),
      .en   (en),
      .num  (f_num[i]),
      .den  (f_den),
      .quo  (f_q[i]),
      .over (f_ov[i])
    );
  end

  // Saturation and sign.
  always_comb begin
    res.sat = 1'b0;
    if (e_ov || e_q[QW-1]) begin
      res.energy = ldrf_pkg::ENERGY_MAX;
      res.sat    = 1'b1;
    end else begin
      res.energy = e_q[EW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      if (fl[LAST].zero[i]) begin
        res.frc[i] = '0;
      end else if (fl[LAST].neg[i]) begin
        if (f_ov[i] || (f_q[i] > ldrf_pkg::FORCE_MIN)) begin
          res.frc[i] = ldrf_pkg::FORCE_MIN;
          res.sat    = 1'b1;
        end else begin
          res.frc[i] = FW'(0) - f_q[i][FW-1:0];
        end
      end else begin
        if (f_ov[i] || f_q[i][QW-1]) begin
          res.frc[i] = ldrf_pkg::FORCE_MAX;
          res.sat    = 1'b1;
        end else begin
          res.frc[i] = f_q[i][FW-1:0];
        end
      end
    end
  end

  // Output register with skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !result.ready) begin
      if (en && v[LAST]) begin
        skid_r <= res;
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_r  <= skid_r;
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_r <= res;
      out_v <= v[LAST];
    end
  end

  assign result.valid     = out_v;
  assign result.energy    = out_r.energy;
  assign result.force_x   = out_r.frc[0];
  assign result.force_y   = out_r.frc[1];
  assign result.force_z   = out_r.frc[2];
  assign result.saturated = out_r.sat;

  `LDRF_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_v, out_v, "skid full with output empty")
  `LDRF_ASSERT_NEXT(a_stall_fills_skid, clk, rst, out_v && !result.ready && !skid_v && v[LAST], skid_v, "stalled result not caught by skid")
  `LDRF_ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && result.ready, out_v && !skid_v, "skid did not drain")

endmodule

### tb/sv/linear_distance_restraint_force_tb.sv
module linear_distance_restraint_force_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] coord_t;

  typedef struct {
    coord_t a[3];
    coord_t b[3];
  } pair_t;

  typedef struct packed {
    logic [ldrf_pkg::ENERGY_WIDTH-1:0] energy;
    logic [ldrf_pkg::FORCE_WIDTH-1:0]  fx;
    logic [ldrf_pkg::FORCE_WIDTH-1:0]  fy;
    logic [ldrf_pkg::FORCE_WIDTH-1:0]  fz;
    logic                              sat;
  } restraint_t;

  typedef struct {
    pair_t      pair;
    bit         typed;
    restraint_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ldrf_cfg_if                      cfg_ch();
  ldrf_point_if #(.COORD_WIDTH(32)) point_ch();
  ldrf_result_if                   result_ch();

  linear_distance_restraint_force #(.FRAC_BITS(16), .COORD_WIDTH(32)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .point  (point_ch),
    .result (result_ch)
  );

  always #4 clk = ~clk;

  logic [ldrf_pkg::PARAM_WIDTH-1:0] alpha;
  logic [ldrf_pkg::PARAM_WIDTH-1:0] target;
  restraint_t             pending_q[$];
  int                     errors;
  int                     n_pairs;
  int                     n_results;
  int                     n_sat;
  int                     hold_cycles;
  bit                     no_idle;

  function automatic restraint_t predict_restraint(pair_t p);
    logic signed [33:0] d[3];
    logic [127:0]       mag[3];
    logic [127:0]       sq, rlen, t, tgt, str, e, num, q;
    logic [ldrf_pkg::FORCE_WIDTH-1:0] f[3];
    restraint_t         r;
    bit                 neg;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = {{2{p.a[i][31]}}, p.a[i]} - {{2{p.b[i][31]}}, p.b[i]};
      mag[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      sq = sq + mag[i] * mag[i];
    end
    rlen = 0;
    for (int k = 40; k >= 0; k--) begin
      t = rlen | (128'd1 << k);
      if (t * t <= sq) rlen = t;
    end
    tgt = target == 0 ? 128'd1 : 128'(target);
    str = 128'(alpha);
    r.sat = 1'b0;
    e = str * rlen / tgt;
    if (e > 128'(ldrf_pkg::ENERGY_MAX)) begin
      r.energy = ldrf_pkg::ENERGY_MAX;
      r.sat = 1'b1;
    end else begin
      r.energy = e[ldrf_pkg::ENERGY_WIDTH-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      f[i] = '0;
      if (rlen != 0 && rlen != tgt && mag[i] != 0) begin
        neg = (d[i] < 0) != (rlen > tgt);
        num = (str * mag[i]) << 16;
        q = num / (tgt * rlen);
        if (neg) begin
          if (q > 128'h8000_0000) begin
            f[i] = ldrf_pkg::FORCE_MIN;
            r.sat = 1'b1;
          end else begin
            f[i] = -q[31:0];
          end
        end else if (q > 128'(ldrf_pkg::FORCE_MAX)) begin
          f[i] = ldrf_pkg::FORCE_MAX;
          r.sat = 1'b1;
        end else begin
          f[i] = q[31:0];
        end
      end
    end
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    return r;
  endfunction

  function automatic pair_t make_pair(coord_t ax, coord_t ay, coord_t az,
                                      coord_t bx, coord_t by, coord_t bz);
    pair_t p;
    p.a[0] = ax; p.a[1] = ay; p.a[2] = az;
    p.b[0] = bx; p.b[1] = by; p.b[2] = bz;
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    shape;
    int    span;
    shape = $urandom_range(99);
    span = $urandom_range(4, 24);
    for (int i = 0; i < 3; i++) begin
      p.b[i] = $urandom;
      if (shape < 25) p.a[i] = $urandom;
      else p.a[i] = p.b[i] + coord_t'($signed($urandom) >>> (31 - span));
    end
    if (shape >= 90 && shape < 95) p.a = p.b;
    if (shape >= 95) begin
      p.a = p.b;
      p.a[$urandom_range(2)] += (target == 0 ? 32'sd1 : coord_t'(target));
    end
    return p;
  endfunction

  task automatic write_reg(logic [ldrf_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           logic [ldrf_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == ldrf_pkg::REG_STRENGTH) alpha = val[ldrf_pkg::PARAM_WIDTH-1:0];
    else if (idx == ldrf_pkg::REG_TARGET) target = val[ldrf_pkg::PARAM_WIDTH-1:0];
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pair(pair_t p, bit typed, restraint_t want);
    point_ch.valid   <= 1'b1;
    point_ch.pos_a_x <= p.a[0];
    point_ch.pos_a_y <= p.a[1];
    point_ch.pos_a_z <= p.a[2];
    point_ch.pos_b_x <= p.b[0];
    point_ch.pos_b_y <= p.b[1];
    point_ch.pos_b_z <= p.b[2];
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    pending_q.push_back(typed ? want : predict_restraint(p));
    n_pairs++;
    if (!no_idle && $urandom_range(99) < 7) begin
      point_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    restraint_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.energy, result_ch.force_x, result_ch.force_y, result_ch.force_z,
             result_ch.saturated};
      n_results++;
      if (got.sat) n_sat++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.energy !== want.energy)
          $display("%0t: energy expected %h actual %h", $time, want.energy, got.energy);
        if (got.fx !== want.fx)
          $display("%0t: force_x expected %h actual %h", $time, want.fx, got.fx);
        if (got.fy !== want.fy)
          $display("%0t: force_y expected %h actual %h", $time, want.fy, got.fy);
        if (got.fz !== want.fz)
          $display("%0t: force_z expected %h actual %h", $time, want.fz, got.fz);
        if (got.sat !== want.sat)
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t                   dir_tab[$];
    row_t                   row;
    logic [ldrf_pkg::CFG_DATA_WIDTH-1:0] str_set[6];
    logic [ldrf_pkg::CFG_DATA_WIDTH-1:0] tgt_set[6];
    coord_t                 one, mx, mn;
    restraint_t             nil;
    one = 32'sh0001_0000;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    nil = '0;
    alpha = ldrf_pkg::STRENGTH_RESET;
    target = ldrf_pkg::TARGET_RESET;
    errors = 0;
    n_pairs = 0;
    n_results = 0;
    n_sat = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    point_ch.valid <= 1'b0;
    point_ch.pos_a_x <= '0;
    point_ch.pos_a_y <= '0;
    point_ch.pos_a_z <= '0;
    point_ch.pos_b_x <= '0;
    point_ch.pos_b_y <= '0;
    point_ch.pos_b_z <= '0;
    result_ch.ready <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run with the reset values of both registers.
    row = '{make_pair(0, 0, 0, 0, 0, 0), 1'b1, nil};
    dir_tab.push_back(row);
    row = '{make_pair(mx, mn, 5, mx, mn, 5), 1'b1, nil};
    dir_tab.push_back(row);
    row = '{make_pair(one, 0, 0, 0, 0, 0), 1'b1, {31'd65536, 32'd0, 32'd0, 32'd0, 1'b0}};
    dir_tab.push_back(row);
    row = '{make_pair(0, 0, 0, 0, 2 * one, 0), 1'b1,
            {31'd131072, 32'd0, 32'h0001_0000, 32'd0, 1'b0}};
    dir_tab.push_back(row);
    row = '{make_pair(0, 0, 0, 0, 0, -one), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(mx, mx, mx, mn, mn, mn), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(mn, mn, mn, mx, mx, mx), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(mx, 0, 0, mn, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(1, 0, 0, 0, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(-1, 1, -1, 0, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(one / 2, 0, 0, 0, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(0, -3 * one, 4 * one, 0, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    row = '{make_pair(-1, -1, -1, 0, 0, 0), 1'b0, nil};
    dir_tab.push_back(row);
    foreach (dir_tab[i]) send_pair(dir_tab[i].pair, dir_tab[i].typed, dir_tab[i].want);
    drain();

    str_set = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0};
    tgt_set = '{32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0};
    str_set[4] = $urandom;
    tgt_set[4] = $urandom_range(1, 32'h0010_0000);
    str_set[5] = $urandom_range(0, 32'h0100_0000);
    tgt_set[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ldrf_pkg::REG_STRENGTH, str_set[ph]);
      write_reg(ldrf_pkg::REG_TARGET, tgt_set[ph]);
      no_idle = (ph == 2);
      if (ph == 1) hold_cycles = 400;
      for (int n = 0; n < 165; n++) send_pair(random_pair(), 1'b0, nil);
      drain();
    end

    $display("Covered %0d point pairs and %0d results, %0d of them saturated,", n_pairs,
             n_results, n_sat);
    $display("over seven register settings including zero and full-scale values.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
